### hw/rtl/ssfd_pkg.sv
// shared types, constants and the segment decode for the seven-segment frame decoder
package ssfd_pkg;

   // longest version string, start byte included
   localparam int VERSION_MAX = 16;
   // byte counter covers frame positions up to four and version positions below VERSION_MAX
   localparam int CNT_W = ($clog2(VERSION_MAX) > 3) ? $clog2(VERSION_MAX) : 3;

   localparam int MINUTES_W = 13;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_FRAME,
      PH_VERSION
   } phase_type;

   typedef enum logic [1:0] {
      EV_FRAME,
      EV_VER_OK,
      EV_VER_BAD,
      EV_VER_OVF
   } event_type;

   typedef enum logic [2:0] {
      M_UNKNOWN,
      M_OFF,
      M_IDLE,
      M_WARM,
      M_LOW,
      M_HIGH
   } mode_type;

   // start bytes
   localparam logic [7:0] LEAD_OFF     = 8'h80;
   localparam logic [7:0] LEAD_LOW     = 8'h81;
   localparam logic [7:0] LEAD_WARM    = 8'h82;
   localparam logic [7:0] LEAD_HIGH    = 8'h84;
   localparam logic [7:0] LEAD_IDLE    = 8'h87;
   localparam logic [7:0] LEAD_VERSION = 8'h88;

   localparam logic [7:0] CHAR_V    = 8'h56;
   localparam logic [7:0] BYTE_NULL = 8'h00;

   localparam logic [3:0] DIGIT_BAD = 4'd10;
   localparam int         FRAME_LAST = 4;

   // segment patterns for digits 0 to 9
   localparam logic [7:0] SEG_TABLE [10] = '{
      8'h7e, 8'h30, 8'h6d, 8'h79, 8'h33, 8'h5b, 8'h5f, 8'h70, 8'h7f, 8'h7b
   };

   // digit value, or DIGIT_BAD for an unknown pattern
   function automatic logic [3:0] seg_decode(input logic [7:0] seg);
      logic [3:0] val;
      val = DIGIT_BAD;
      for (int i = 0; i < 10; i++) begin
         if (SEG_TABLE[i] == seg) begin
            val = 4'(i);
         end
      end
      return val;
   endfunction

endpackage

### hw/rtl/seven_segment_frame_decoder.sv
// seven-segment display frame decoder: byte parser, mode and cook-time tracking
//
// req channel: one received link byte per transfer (req_rx_byte)
// rsp channel: zero or one event per byte; a display frame ends on its fifth
//   byte, a version string on its zero byte or when VERSION_MAX bytes have
//   arrived (0x88 start byte counted), giving an overflow event
// rsp fields: event kind, kept appliance mode, kept minutes left, and a flag
//   set when a frame assigned the minutes
// path: a byte waits in the input register and its event is written to the
//   result register once that register is free, so rsp_valid rises only after
//   the byte that closes it has passed both registers
// throughput: one byte per cycle while the result register is free, set by the
//   single decode pass between the input register and the result register
// stall: the result register holds while rsp_ready is low; the input register
//   then keeps its byte and req_ready drops once it is full
// reset: hunt phase, counter cleared, mode unknown, minutes zero, both
//   registers empty
module seven_segment_frame_decoder
   import ssfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_event_kind,
   output logic [2:0]           rsp_appliance_mode,
   output logic [MINUTES_W-1:0] rsp_minutes_left,
   output logic                 rsp_time_updated
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       lead_ff, lead_in;
   logic [7:0]       dig0_ff, dig0_in;
   logic [7:0]       dig1_ff, dig1_in;
   logic [7:0]       dig2_ff, dig2_in;
   mode_type         mode_ff, mode_in;
   logic [MINUTES_W-1:0] time_ff, time_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   event_type            kind_ff, kind_in;
   mode_type             out_mode_ff;
   logic [MINUTES_W-1:0] out_time_ff;
   logic                 upd_ff, upd_in;

   logic emit;
   logic out_free;
   logic advance;

   // decoded digits of the frame in flight
   logic [3:0] h1, h0, m1, m0;
   logic [6:0] hours, mins;
   logic [7:0] first_char;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   // next state of the parser
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      lead_in  = lead_ff;
      dig0_in  = dig0_ff;
      dig1_in  = dig1_ff;
      dig2_in  = dig2_ff;
      unique case (phase_ff)
         PH_FRAME: begin
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(1)) dig0_in = in_byte_ff;
            if (count_ff == CNT_W'(2)) dig1_in = in_byte_ff;
            if (count_ff == CNT_W'(3)) dig2_in = in_byte_ff;
            // last segment byte closes the frame
            if (count_ff >= CNT_W'(FRAME_LAST)) begin
               count_in = '0;
               phase_in = PH_HUNT;
            end
         end
         PH_VERSION: begin
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(1)) dig0_in = in_byte_ff;
            if (in_byte_ff == BYTE_NULL || count_ff >= CNT_W'(VERSION_MAX - 1)) begin
               count_in = '0;
               phase_in = PH_HUNT;
            end
         end
         default: begin
            // hunt, and the unused phase code
            if (in_byte_ff == LEAD_OFF || in_byte_ff == LEAD_LOW || in_byte_ff == LEAD_WARM
                || in_byte_ff == LEAD_HIGH || in_byte_ff == LEAD_IDLE) begin
               lead_in  = in_byte_ff;
               count_in = CNT_W'(1);
               phase_in = PH_FRAME;
            end else if (in_byte_ff == LEAD_VERSION) begin
               count_in = CNT_W'(1);
               phase_in = PH_VERSION;
            end else begin
               count_in = '0;
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   // digit decode for the closing frame byte
   always_comb begin
      h1    = seg_decode(dig0_ff);
      h0    = seg_decode(dig1_ff);
      m1    = seg_decode(dig2_ff);
      m0    = seg_decode(in_byte_ff);
      hours = 7'(h1) * 7'd10 + 7'(h0);
      // a bad last digit leaves the first minute digit alone
      mins  = (m0 < DIGIT_BAD) ? (7'(m1) * 7'd10 + 7'(m0)) : 7'(m1);
      first_char = (count_ff == CNT_W'(1)) ? in_byte_ff : dig0_ff;
   end

   // result and kept mode / minutes
   always_comb begin
      emit    = 1'b0;
      kind_in = EV_FRAME;
      upd_in  = 1'b0;
      mode_in = mode_ff;
      time_in = time_ff;
      unique case (phase_ff)
         PH_FRAME: begin
            if (count_ff >= CNT_W'(FRAME_LAST)) begin
               emit = 1'b1;
               unique case (lead_ff)
                  LEAD_OFF:  if (mode_ff != M_IDLE) mode_in = M_OFF;
                  LEAD_IDLE: mode_in = M_IDLE;
                  LEAD_LOW:  mode_in = M_LOW;
                  LEAD_WARM: mode_in = M_WARM;
                  LEAD_HIGH: mode_in = M_HIGH;
                  default:   mode_in = mode_ff;
               endcase
               if (dig0_ff == BYTE_NULL && dig1_ff == BYTE_NULL && dig2_ff == BYTE_NULL
                   && in_byte_ff == BYTE_NULL) begin
                  // blank display
                  time_in = '0;
                  upd_in  = 1'b1;
               end else if (h1 < DIGIT_BAD && h0 < DIGIT_BAD && m1 < DIGIT_BAD) begin
                  time_in = MINUTES_W'(hours) * MINUTES_W'(60) + MINUTES_W'(mins);
                  upd_in  = 1'b1;
               end
            end
         end
         PH_VERSION: begin
            if (in_byte_ff == BYTE_NULL) begin
               emit    = 1'b1;
               kind_in = (first_char == CHAR_V) ? EV_VER_OK : EV_VER_BAD;
            end else if (count_ff >= CNT_W'(VERSION_MAX - 1)) begin
               emit    = 1'b1;
               kind_in = EV_VER_OVF;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         mode_ff      <= M_UNKNOWN;
         time_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            mode_ff  <= mode_in;
            time_ff  <= time_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         lead_ff <= lead_in;
         dig0_ff <= dig0_in;
         dig1_ff <= dig1_in;
         dig2_ff <= dig2_in;
      end
      if (advance && emit) begin
         kind_ff     <= kind_in;
         out_mode_ff <= mode_in;
         out_time_ff <= time_in;
         upd_ff      <= upd_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_appliance_mode = out_mode_ff;
   assign rsp_minutes_left   = out_time_ff;
   assign rsp_time_updated   = upd_ff;

   // only display frames assign the minutes
   a_upd_frame_only: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff != EV_FRAME |-> !upd_ff)
      else $error("time update flagged on a version event");

   // minutes never pass 99:99
   a_minutes_range: assert property (@(posedge clock) disable iff (reset)
      time_ff <= MINUTES_W'(6039))
      else $error("minutes left out of range");

   // frame position stays within the five-byte frame
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FRAME |-> count_ff >= CNT_W'(1) && count_ff <= CNT_W'(FRAME_LAST))
      else $error("frame byte counter out of range");

   // hunting keeps the counter clear
   a_hunt_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> count_ff == '0)
      else $error("byte counter not cleared in hunt");

   // version counter stops at the buffer limit
   a_version_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VERSION |-> count_ff <= CNT_W'(VERSION_MAX - 1))
      else $error("version byte counter past limit");

endmodule

### tb/tb.sv
// self-checking testbench for the seven-segment frame decoder
module tb;
   import ssfd_pkg::*;

   // run guard, far above the slowest correct run
   localparam int CYCLE_LIMIT = 400000;
   // cycles to let pass once nothing is awaited, covers the two-stage pipe
   localparam int SETTLE_CYCLES = 8;
   // how long the receiver holds off in the back-pressure test
   localparam int HOLD_CYCLES = 300;
   localparam int GAP_MAX = 20;

   localparam logic [7:0] FRAME_LEADS [5] = '{
      LEAD_OFF, LEAD_LOW, LEAD_WARM, LEAD_HIGH, LEAD_IDLE
   };
   localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
      8'h7e, 8'h30, 8'h6d, 8'h79, 8'h33, 8'h5b, 8'h5f, 8'h70, 8'h7f, 8'h7b
   };

   // one event as it should leave the rsp channel
   typedef struct packed {
      event_type              kind;
      mode_type               mode;
      logic [MINUTES_W-1:0]   minutes;
      logic                   updated;
   } link_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_event_kind;
   logic [2:0]           rsp_appliance_mode;
   logic [MINUTES_W-1:0] rsp_minutes_left;
   logic                 rsp_time_updated;

   // events still owed by the block, oldest first
   link_report_type expected_reports [$];

   int error_count = 0;
   int sent_bytes = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_rsp = 1'b0;

   // parser state mirrored on the testbench side
   phase_type            link_phase = PH_HUNT;
   int unsigned          link_pos = 0;
   logic [7:0]           frame_lead = 8'h00;
   logic [7:0]           frame_segs [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
   logic [7:0]           version_first = 8'h00;
   mode_type             mode_kept = M_UNKNOWN;
   logic [MINUTES_W-1:0] minutes_kept = '0;

   seven_segment_frame_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_appliance_mode (rsp_appliance_mode),
      .rsp_minutes_left   (rsp_minutes_left),
      .rsp_time_updated   (rsp_time_updated)
   );

   always #6 clock = ~clock;

   // digit shown by a segment pattern, -1 when it is not a digit
   function automatic int segment_digit(input logic [7:0] seg);
      case (seg)
         8'h7e: return 0;
         8'h30: return 1;
         8'h6d: return 2;
         8'h79: return 3;
         8'h33: return 4;
         8'h5b: return 5;
         8'h5f: return 6;
         8'h70: return 7;
         8'h7f: return 8;
         8'h7b: return 9;
         default: return -1;
      endcase
   endfunction

   // push the report a closed frame or version string owes
   function automatic void owe_report(input event_type kind, input logic updated);
      link_report_type rep;
      rep.kind    = kind;
      rep.mode    = mode_kept;
      rep.minutes = minutes_kept;
      rep.updated = updated;
      expected_reports.push_back(rep);
   endfunction

   // advance the mirrored parser by one accepted byte
   function automatic void track_link_byte(input logic [7:0] b);
      int unsigned pos;
      int h1, h0, m1, m0, mins;
      logic updated;
      pos = link_pos;
      link_pos = link_pos + 1;
      case (link_phase)
         PH_FRAME: begin
            if (pos >= 1 && pos <= 4) begin
               frame_segs[pos-1] = b;
            end
            if (link_pos >= 5) begin
               // lead byte picks the mode; off never overrides idle
               case (frame_lead)
                  LEAD_OFF: begin
                     if (mode_kept != M_IDLE) begin
                        mode_kept = M_OFF;
                     end
                  end
                  LEAD_IDLE: mode_kept = M_IDLE;
                  LEAD_LOW:  mode_kept = M_LOW;
                  LEAD_WARM: mode_kept = M_WARM;
                  LEAD_HIGH: mode_kept = M_HIGH;
                  default: ;
               endcase
               updated = 1'b0;
               if (frame_segs[0] == 8'h00 && frame_segs[1] == 8'h00 &&
                   frame_segs[2] == 8'h00 && frame_segs[3] == 8'h00) begin
                  // blank display means no time left
                  minutes_kept = '0;
                  updated = 1'b1;
               end else begin
                  h1 = segment_digit(frame_segs[0]);
                  h0 = segment_digit(frame_segs[1]);
                  m1 = segment_digit(frame_segs[2]);
                  m0 = segment_digit(frame_segs[3]);
                  if (h1 >= 0 && h0 >= 0 && m1 >= 0) begin
                     // a bad last digit leaves the tens digit as the minutes
                     mins = (m0 >= 0) ? m1 * 10 + m0 : m1;
                     minutes_kept = MINUTES_W'((h1 * 10 + h0) * 60 + mins);
                     updated = 1'b1;
                  end
               end
               owe_report(EV_FRAME, updated);
               link_pos = 0;
               link_phase = PH_HUNT;
            end
         end
         PH_VERSION: begin
            if (pos == 1) begin
               version_first = b;
            end
            if (b == BYTE_NULL) begin
               owe_report((version_first == CHAR_V) ? EV_VER_OK : EV_VER_BAD, 1'b0);
               link_pos = 0;
               link_phase = PH_HUNT;
            end else if (link_pos >= VERSION_MAX) begin
               owe_report(EV_VER_OVF, 1'b0);
               link_pos = 0;
               link_phase = PH_HUNT;
            end
         end
         default: begin
            if (b == LEAD_OFF || b == LEAD_LOW || b == LEAD_WARM ||
                b == LEAD_HIGH || b == LEAD_IDLE) begin
               frame_lead = b;
               link_pos = 1;
               link_phase = PH_FRAME;
            end else if (b == LEAD_VERSION) begin
               link_pos = 1;
               link_phase = PH_VERSION;
            end else begin
               link_pos = 0;
               link_phase = PH_HUNT;
            end
         end
      endcase
   endfunction

   // offer one byte, after a random idle gap, and hold it until the transfer
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      // valid stays up here; the next call or a drain decides what follows
      do @(posedge clock); while (!req_ready);
      track_link_byte(b);
      sent_bytes++;
   endtask

   task automatic send_frame(input logic [7:0] lead, input logic [7:0] h1,
                             input logic [7:0] h0, input logic [7:0] m1,
                             input logic [7:0] m0);
      send_byte(lead);
      send_byte(h1);
      send_byte(h0);
      send_byte(m1);
      send_byte(m0);
   endtask

   // start byte, first character, filler, then the zero byte if asked
   task automatic send_version(input logic [7:0] first, input int filler,
                               input bit terminate);
      send_byte(LEAD_VERSION);
      send_byte(first);
      repeat (filler) send_byte(8'($urandom_range(1, 255)));
      if (terminate) begin
         send_byte(BYTE_NULL);
      end
   endtask

   // mostly real digits, some blanks, some garbage
   function automatic logic [7:0] pick_segment();
      int r;
      r = $urandom_range(99);
      if (r < 65) return DIGIT_SEGMENTS[$urandom_range(9)];
      if (r < 78) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   // stop offering and wait until every owed event has left the block
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_display_frames();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // largest time 99:99, mode leaves unknown for off
      send_frame(LEAD_OFF, 8'h7b, 8'h7b, 8'h7b, 8'h7b);
      // blank display clears the time, idle
      send_frame(LEAD_IDLE, 8'h00, 8'h00, 8'h00, 8'h00);
      // off while idle keeps idle; bad last digit gives 12:4
      send_frame(LEAD_OFF, 8'h30, 8'h6d, 8'h33, 8'h00);
      // bad hour digit keeps the time
      send_frame(LEAD_LOW, 8'h00, 8'h7e, 8'h7e, 8'h7e);
      // bad minute tens digit keeps the time
      send_frame(LEAD_WARM, 8'h7e, 8'h7e, 8'hff, 8'h7e);
   endtask

   task automatic test_version_strings();
      // empty string is invalid
      send_version(BYTE_NULL, 0, 1'b0);
      send_version(CHAR_V, 1, 1'b1);
      send_version(8'h58, 0, 1'b1);
      // fills the buffer with no zero byte
      send_version(CHAR_V, VERSION_MAX - 2, 1'b0);
   endtask

   // well-formed frames and strings with random content, plus noise
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int byte_budget);
      int stop_at, r;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = sent_bytes + byte_budget;
      while (sent_bytes < stop_at) begin
         r = $urandom_range(99);
         if (r < 6) begin
            send_frame(FRAME_LEADS[$urandom_range(4)], 8'h00, 8'h00, 8'h00, 8'h00);
         end else if (r < 60) begin
            send_frame(FRAME_LEADS[$urandom_range(4)], pick_segment(), pick_segment(),
                       pick_segment(), pick_segment());
         end else if (r < 65) begin
            send_version(BYTE_NULL, 0, 1'b0);
         end else if (r < 82) begin
            send_version(($urandom_range(1)) ? CHAR_V : 8'($urandom_range(1, 255)),
                         $urandom_range(0, VERSION_MAX + 2), 1'b1);
         end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // receiver holds off long enough for the input side to back up
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      repeat (10) begin
         send_frame(FRAME_LEADS[$urandom_range(4)], pick_segment(), pick_segment(),
                    pick_segment(), pick_segment());
      end
   endtask

   // receiver side, random stalls unless held off
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // compare each rsp transfer with the oldest owed event
   always @(posedge clock) begin
      link_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            error_count++;
            $display("%0t: unexpected event kind %0d mode %0d minutes %0d updated %0d",
                     $time, rsp_event_kind, rsp_appliance_mode, rsp_minutes_left,
                     rsp_time_updated);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_event_kind != want.kind) begin
               error_count++;
               $display("%0t: event kind expected %0d actual %0d",
                        $time, want.kind, rsp_event_kind);
            end
            if (rsp_appliance_mode != want.mode) begin
               error_count++;
               $display("%0t: appliance mode expected %0d actual %0d",
                        $time, want.mode, rsp_appliance_mode);
            end
            if (rsp_minutes_left != want.minutes) begin
               error_count++;
               $display("%0t: minutes left expected %0d actual %0d",
                        $time, want.minutes, rsp_minutes_left);
            end
            if (rsp_time_updated != want.updated) begin
               error_count++;
               $display("%0t: time updated expected %0d actual %0d",
                        $time, want.updated, rsp_time_updated);
            end
         end
      end
   end

   // run guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_display_frames();
      test_version_strings();
      // sender pauses until every owed event is out
      wait_for_reports();
      test_random_traffic(0, 0, 460);
      test_random_traffic(70, 0, 460);
      test_backpressure();
      wait_for_reports();
      test_random_traffic(0, 70, 460);
      test_random_traffic(13, 13, 460);
      wait_for_reports();
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
